// ===== sv/crcfr_pkg.sv =====
// crcfr_pkg: shared types, frame constants and the CRC-8 byte step
// for the framed packet receiver. No dependencies.
`timescale 1ns / 1ps

package crcfr_pkg;

    localparam logic [7:0] PREAMBLE0 = 8'hAC;
    localparam logic [7:0] PREAMBLE1 = 8'h53;
    localparam logic [7:0] CRC_POLY  = 8'h31;
    localparam logic [7:0] LEN_MIN   = 8'd4;
    localparam logic [7:0] LEN_MAX   = 8'd253;

    // frame positions, counted from 1 at the first preamble byte
    localparam int POS_PRE0    = 1;
    localparam int POS_PRE1    = 2;
    localparam int POS_LEN     = 3;
    localparam int POS_SEQ     = 4;
    localparam int POS_ADDR    = 5;
    localparam int POS_PAYLOAD = 6;

    // frame end compare: count and length + 3 both fit here
    localparam int END_W = 9;

    localparam int REG_EXPECTED_SEQUENCE = 0;
    localparam int REG_DEVICE_ADDRESS    = 1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic       frame_ok;
        logic       err_preamble;
        logic       err_length;
        logic       err_sequence;
        logic       err_address;
        logic       err_crc;
        logic       err_too_big;
    } res_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== sv/crcfr_core.sv =====
// crcfr_core: frame state registers and per-byte check logic.
// Depends on crcfr_pkg.
`timescale 1ns / 1ps

module crcfr_core #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        expected_sequence,
    input  logic [7:0]        device_address,
    output logic              has_result,
    output crcfr_pkg::res_t   result
);
    import crcfr_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       length_field_reg, length_field_next;
    logic [7:0]       crc_reg, crc_next;
    logic             fpo_reg, fpo_next;

    logic [CNT_W-1:0] cnt;
    logic [END_W-1:0] cnt_e;
    logic [END_W-1:0] len_end;
    logic [7:0]       len;
    logic [7:0]       v;
    logic [7:0]       crc;
    logic             complete;
    logic             ep, el, es, ea, ec, et;
    logic             any_err;
    logic             frame_end;

    always_comb
    begin
        cnt      = byte_count_reg + CNT_W'(1);
        cnt_e    = END_W'(cnt);
        len      = (cnt == CNT_W'(POS_LEN)) ? rx_byte : length_field_reg;
        len_end  = END_W'(len) + END_W'(3);
        complete = (cnt_e >= END_W'(POS_LEN)) && (cnt_e == len_end);
        v        = complete ? 8'd0 : rx_byte;
        fpo_next = (cnt == CNT_W'(POS_PRE0)) ? (rx_byte == PREAMBLE0) : fpo_reg;

        ep = (cnt == CNT_W'(POS_PRE1)) && !(fpo_reg && rx_byte == PREAMBLE1);
        el = (cnt_e >= END_W'(POS_LEN)) && ((len < LEN_MIN) || (len > LEN_MAX));
        es = (cnt == CNT_W'(POS_SEQ)) && (v != expected_sequence);
        ea = (cnt == CNT_W'(POS_ADDR)) && (v != device_address);
        crc = crc8_step(crc_reg, v);
        ec = complete && (rx_byte != crc);
        et = cnt > CNT_W'(MAX_FRAME_BYTES);

        any_err   = ep || el || es || ea || ec || et;
        frame_end = any_err || complete;

        result.kind         = frame_end ? KIND_STATUS : KIND_PAYLOAD;
        result.payload_byte = frame_end ? 8'd0 : rx_byte;
        result.frame_ok     = frame_end && !any_err;
        result.err_preamble = ep;
        result.err_length   = el;
        result.err_sequence = es;
        result.err_address  = ea;
        result.err_crc      = ec;
        result.err_too_big  = et;
        has_result = frame_end || (cnt >= CNT_W'(POS_PAYLOAD));

        if (frame_end)
        begin
            byte_count_next   = '0;
            length_field_next = 8'd0;
            crc_next          = 8'd0;
        end
        else
        begin
            byte_count_next   = cnt;
            length_field_next = len;
            crc_next          = crc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            length_field_reg <= 8'd0;
            crc_reg          <= 8'd0;
            fpo_reg          <= 1'b0;
        end
        else if (step)
        begin
            byte_count_reg   <= byte_count_next;
            length_field_reg <= length_field_next;
            crc_reg          <= crc_next;
            fpo_reg          <= frame_end ? 1'b0 : fpo_next;
        end
    end

endmodule

// ===== sv/crc8_framed_packet_receiver.sv =====
// crc8_framed_packet_receiver: top level with input register, config
// registers and output register. Depends on crcfr_pkg and crcfr_core.
`timescale 1ns / 1ps

// Takes one received byte per cycle while the output is not stalled, and checks
// frames of the form AC 53, length (4..253), sequence, address, payload, CRC-8
// (poly 0x31, init 0, MSB first, zero in the CRC position). Payload bytes come
// out as kind 0 items; the first failed check or the frame end gives one kind 1
// status item and the receiver goes back to waiting for a preamble. A byte is
// taken into the input register and its result into the output register before
// the result is offered, and a stalled output holds off input after one more
// byte.
// Header bytes that pass give no item. Config writes belong to idle periods.

module crc8_framed_packet_receiver #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [8] frame_ok, [9] err_preamble,
                                   // [10] err_length, [11] err_sequence, [12] err_address,
                                   // [13] err_crc, [14] err_too_big, [15] zero
    output logic        m_tuser,   // [0] result_kind
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import crcfr_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic [7:0] exp_seq_reg;
    logic [7:0] dev_addr_reg;
    logic       out_valid_reg;
    res_t       out_reg;

    logic       out_free;
    logic       step;
    logic       has_result;
    res_t       result;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    crcfr_core #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .rx_byte          (in_byte_reg),
        .expected_sequence(exp_seq_reg),
        .device_address   (dev_addr_reg),
        .has_result       (has_result),
        .result           (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_seq_reg  <= 8'd0;
            dev_addr_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                1'(REG_EXPECTED_SEQUENCE): exp_seq_reg  <= cfg_data;
                1'(REG_DEVICE_ADDRESS):    dev_addr_reg <= cfg_data;
                default:                   exp_seq_reg  <= exp_seq_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (step && has_result)
            out_reg <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= step && has_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {1'b0, out_reg.err_too_big, out_reg.err_crc, out_reg.err_address,
                       out_reg.err_sequence, out_reg.err_length, out_reg.err_preamble,
                       out_reg.frame_ok, out_reg.payload_byte};

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for crc8_framed_packet_receiver; feeds framed and
// broken byte streams, predicts every payload and status item and checks them.
// Depends on crcfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module testbench;

    import crcfr_pkg::*;

    localparam int  MAX_FRAME_BYTES = 256;
    localparam real CLK_PERIOD      = 12.0;
    localparam int  PHASE_BYTES     = 250;
    localparam int  HOLD_CYCLES     = 300;
    localparam int  SETTLE_CYCLES   = 8;

    typedef enum int {
        FLAW_NONE,
        FLAW_CRC,
        FLAW_SEQ,
        FLAW_ADDR
    } frame_flaw_t;

    class frame_checker #(int LIMIT = 256);
        res_t        expected_items[$];
        logic [8:0]  count;
        logic [7:0]  len_byte;
        logic [7:0]  crc_acc;
        logic        pre0_seen;
        logic [7:0]  seq_cfg;
        logic [7:0]  addr_cfg;
        int          errors;
        int          taken;

        function new();
            seq_cfg   = 8'h00;
            addr_cfg  = 8'h01;
            count     = '0;
            len_byte  = '0;
            crc_acc   = '0;
            pre0_seen = 1'b0;
            errors    = 0;
            taken     = 0;
        endfunction

        function logic [7:0] crc_next(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            logic       fb;
            c = crc;
            for (int i = 7; i >= 0; i--)
            begin
                fb = c[7] ^ b[i];
                c  = {c[6:0], 1'b0};
                if (fb)
                    c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function void set_reg(int idx, logic [7:0] val);
            if (idx == REG_EXPECTED_SEQUENCE)
                seq_cfg = val;
            else if (idx == REG_DEVICE_ADDRESS)
                addr_cfg = val;
        endfunction

        function bit at_idle();
            return count == 0;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [8:0] cnt;
            logic [7:0] v;
            logic [7:0] crc;
            logic       complete;
            logic       ep, el, es, ea, ec, et;
            res_t       r;
            cnt = count + 9'd1;
            ep  = 1'b0;
            el  = 1'b0;
            es  = 1'b0;
            ea  = 1'b0;
            ec  = 1'b0;
            if (cnt == POS_LEN)
                len_byte = b;
            complete = (cnt >= POS_LEN) && (cnt == {1'b0, len_byte} + 9'd3);
            // the CRC position counts as a zero byte
            v = complete ? 8'h00 : b;
            if (cnt == POS_PRE0)
                pre0_seen = (b == PREAMBLE0);
            if (cnt == POS_PRE1)
                ep = !(pre0_seen && b == PREAMBLE1);
            if (cnt >= POS_LEN)
                el = (len_byte < LEN_MIN) || (len_byte > LEN_MAX);
            if (cnt == POS_SEQ)
                es = (v != seq_cfg);
            if (cnt == POS_ADDR)
                ea = (v != addr_cfg);
            crc = crc_next(crc_acc, v);
            if (complete)
                ec = (b != crc);
            et = (cnt > LIMIT);
            r = '0;
            taken++;
            if (ep || el || es || ea || ec || et || complete)
            begin
                r.kind         = KIND_STATUS;
                r.frame_ok     = !(ep || el || es || ea || ec || et);
                r.err_preamble = ep;
                r.err_length   = el;
                r.err_sequence = es;
                r.err_address  = ea;
                r.err_crc      = ec;
                r.err_too_big  = et;
                expected_items.push_back(r);
                count     = '0;
                len_byte  = '0;
                crc_acc   = '0;
                pre0_seen = 1'b0;
            end
            else
            begin
                count   = cnt;
                crc_acc = crc;
                if (cnt >= POS_PAYLOAD)
                begin
                    r.kind         = KIND_PAYLOAD;
                    r.payload_byte = b;
                    expected_items.push_back(r);
                end
            end
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_item(logic kind, logic [15:0] data);
            res_t want;
            if (expected_items.size() == 0)
            begin
                $error("item with nothing expected: kind %0h data %0h", kind, data);
                errors++;
                return;
            end
            want = expected_items.pop_front();
            compare("result_kind", 8'(want.kind), 8'(kind));
            compare("payload_byte", want.payload_byte, data[7:0]);
            compare("frame_ok", 8'(want.frame_ok), 8'(data[8]));
            compare("err_preamble", 8'(want.err_preamble), 8'(data[9]));
            compare("err_length", 8'(want.err_length), 8'(data[10]));
            compare("err_sequence", 8'(want.err_sequence), 8'(data[11]));
            compare("err_address", 8'(want.err_address), 8'(data[12]));
            compare("err_crc", 8'(want.err_crc), 8'(data[13]));
            compare("err_too_big", 8'(want.err_too_big), 8'(data[14]));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    bit calm;
    bit hold_req;

    frame_checker #(MAX_FRAME_BYTES) sb;

    crc8_framed_packet_receiver #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(b);
    endtask

    task automatic send_header(input logic [7:0] len);
        send_byte(PREAMBLE0);
        send_byte(PREAMBLE1);
        send_byte(len);
    endtask

    task automatic send_frame(input int len, input frame_flaw_t flaw);
        logic [7:0] frame_bytes[$];
        logic [7:0] crc;
        int         stop;
        frame_bytes = {PREAMBLE0, PREAMBLE1, 8'(len), sb.seq_cfg, sb.addr_cfg};
        if (flaw == FLAW_SEQ)
            frame_bytes[3] = sb.seq_cfg ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_ADDR)
            frame_bytes[4] = sb.addr_cfg ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < len - 3; i++)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        crc = 8'h00;
        foreach (frame_bytes[i])
            crc = sb.crc_next(crc, frame_bytes[i]);
        crc = sb.crc_next(crc, 8'h00);
        if (flaw == FLAW_CRC)
            crc = crc ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(crc);
        // a failed header check ends the frame at that byte
        stop = (flaw == FLAW_SEQ) ? 4 : (flaw == FLAW_ADDR) ? 5 : frame_bytes.size();
        for (int i = 0; i < stop; i++)
            send_byte(frame_bytes[i]);
    endtask

    task automatic random_frame();
        int pick;
        int len;
        int n;
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 253) : $urandom_range(4, 24);
        if (pick < 70)
            send_frame(len, FLAW_NONE);
        else if (pick < 80)
            send_frame(len, FLAW_CRC);
        else if (pick < 85)
            send_frame(len, FLAW_SEQ);
        else if (pick < 90)
            send_frame(len, FLAW_ADDR);
        else if (pick < 95)
            send_header($urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                             : 8'($urandom_range(254, 255)));
        else
        begin
            n = $urandom_range(1, 6);
            if ($urandom_range(0, 1))
                send_byte(PREAMBLE0);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_items.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx[0];
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic run_phase(input logic [7:0] seq, input logic [7:0] addr);
        int goal;
        settle();
        write_reg(REG_EXPECTED_SEQUENCE, seq);
        write_reg(REG_DEVICE_ADDRESS, addr);
        goal = sb.taken + PHASE_BYTES;
        while (sb.taken < goal)
            random_frame();
        // run out any partial frame so the next config write lands while idle
        while (!sb.at_idle())
            send_byte(8'h00);
    endtask

    // output side
    initial
    begin
        int hold_cnt;
        m_tready = 1'b0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_item(m_tuser, m_tdata);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    initial
    begin
        #(CLK_PERIOD * 300000);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        sb        = new();
        calm      = 1'b0;
        hold_req  = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        send_byte(8'hFF);
        send_byte(8'h00);
        send_header(8'h00);
        send_header(8'hFE);
        send_frame(LEN_MIN, FLAW_NONE);
        send_frame(LEN_MIN, FLAW_CRC);
        send_frame(LEN_MIN, FLAW_SEQ);
        send_frame(LEN_MIN, FLAW_ADDR);

        hold_req = 1'b1;
        run_phase(8'hFF, 8'hFF);

        calm = 1'b1;
        run_phase(8'h00, 8'h00);
        calm = 1'b0;

        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

        settle();
        write_reg(REG_EXPECTED_SEQUENCE, 8'h5A);
        write_reg(REG_DEVICE_ADDRESS, 8'hA5);
        send_frame(LEN_MAX, FLAW_NONE);
        run_phase(8'h5A, 8'hA5);

        settle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_items.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
